@@ hdl/timed_turn_and_drive_sequencer_defines.svh @@
// assertion macros for the turn and drive sequencer
`ifndef TIMED_TURN_AND_DRIVE_SEQUENCER_DEFINES_SVH
`define TIMED_TURN_AND_DRIVE_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define TTDS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TTDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/ttds_pkg.sv @@
package ttds_pkg;

   localparam int unsigned QUEUE_DEPTH_DEF = 8;

   localparam int TIME_W     = 32;
   localparam int DUR_W      = 16;
   localparam int DIST_W     = 10;
   localparam int HEAD_W     = 2;
   localparam int STEP_W     = 4;
   localparam int CFG_IDX_W  = 3;
   localparam int CFG_DATA_W = 16;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 16;

   localparam logic [DUR_W-1:0]  SETTLE_RST     = 16'd100;
   localparam logic [DUR_W-1:0]  QUARTER_RST    = 16'd300;
   localparam logic [DUR_W-1:0]  HALF_RST       = 16'd600;
   localparam logic [DUR_W-1:0]  CELL_RST       = 16'd500;
   localparam logic [DIST_W-1:0] STOP_DIST_RST  = 10'd8;

   localparam logic [DUR_W-1:0]  FINAL_STOP_MS     = 16'd10;
   localparam logic [TIME_W-1:0] CHECK_INTERVAL_MS = 32'd50;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_MOVE  = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_SETTLE    = 3'd0,
      KIND_PIVOT_L   = 3'd1,
      KIND_PIVOT_R   = 3'd2,
      KIND_DRIVE     = 3'd3,
      KIND_STOP_ONLY = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ACT_STOP    = 3'd0,
      ACT_LEFT    = 3'd1,
      ACT_RIGHT   = 3'd2,
      ACT_FORWARD = 3'd3
   } action_type;

   typedef enum logic [CFG_IDX_W-1:0] {
      REG_SETTLE    = 3'd0,
      REG_QUARTER   = 3'd1,
      REG_HALF      = 3'd2,
      REG_CELL      = 3'd3,
      REG_STOP_DIST = 3'd4
   } reg_type;

   function automatic action_type kind_to_action(input kind_type kind);
      action_type act;
      case (kind)
         KIND_PIVOT_L: act = ACT_LEFT;
         KIND_PIVOT_R: act = ACT_RIGHT;
         KIND_DRIVE:   act = ACT_FORWARD;
         default:      act = ACT_STOP;
      endcase
      return act;
   endfunction

endpackage

@@ hdl/timed_turn_and_drive_sequencer.sv @@
// Turn-and-drive sequencer: every accepted request (tick, move, clear or other command) produces
// exactly one response, one request per clock and a response in the cycle after the transfer;
// the rate is set by the single output register, reloaded whenever the previous response is
// taken or absent. A move builds a queue of timed steps (settle, pivot, settle when turning,
// then a one-cell drive and a 10 ms stop) in per-step registers; ticks advance through it using
// wrapping 32-bit millisecond time, check the front distance at most every 50 ms while driving,
// and hold forces the motors to stop without advancing. Registers are written over the csr
// channel, which is always ready.
`include "timed_turn_and_drive_sequencer_defines.svh"

module timed_turn_and_drive_sequencer
   import ttds_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // now_ms[31:0], target_heading[33:32], front_distance_cm[43:34], hold[44], zeros
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // cmd[1:0]
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // motor_action[2:0], busy_res[3], heading[5:4], step_index[9:6], safety_abort[10], zeros
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CFG_IDX_W-1:0]  csr_index,
   input  logic [CFG_DATA_W-1:0] csr_data
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // configuration
   logic [DUR_W-1:0]  settle_ff, quarter_ff, half_ff, cell_ff;
   logic [DIST_W-1:0] stop_dist_ff;

   // step queue
   kind_type         step_kind_ff [QUEUE_DEPTH];
   logic [DUR_W-1:0] step_dur_ff  [QUEUE_DEPTH];

   // sequencer state
   logic [CNT_W-1:0]  qlen_ff, qlen_in;
   logic [CNT_W-1:0]  step_ff, step_in, step_nxt;
   logic              running_ff, running_in, run_mid;
   logic [TIME_W-1:0] start_ff, start_in;
   logic [TIME_W-1:0] last_ff, last_in;
   logic [HEAD_W-1:0] heading_ff, heading_in;
   action_type        drive_ff, drive_in;
   kind_type          cur_kind_ff, cur_kind_in;
   logic [DUR_W-1:0]  cur_dur_ff, cur_dur_in;

   // response register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic              req_fire, move_we, abort;
   logic [TIME_W-1:0] now_ms;
   logic [HEAD_W-1:0] target_heading, rel;
   logic [DIST_W-1:0] front_distance_cm;
   logic              hold;
   logic [IDX_W-1:0]  nxt_idx;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign now_ms            = req_tdata[31:0];
   assign target_heading    = req_tdata[33:32];
   assign front_distance_cm = req_tdata[43:34];
   assign hold              = req_tdata[44];
   assign rel               = target_heading - heading_ff;
   assign step_nxt          = step_ff + 1'b1;
   assign nxt_idx           = step_nxt[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff    <= SETTLE_RST;
         quarter_ff   <= QUARTER_RST;
         half_ff      <= HALF_RST;
         cell_ff      <= CELL_RST;
         stop_dist_ff <= STOP_DIST_RST;
      end else if (csr_valid && csr_ready) begin
         case (reg_type'(csr_index))
            REG_SETTLE:    settle_ff    <= csr_data;
            REG_QUARTER:   quarter_ff   <= csr_data;
            REG_HALF:      half_ff      <= csr_data;
            REG_CELL:      cell_ff      <= csr_data;
            REG_STOP_DIST: stop_dist_ff <= csr_data[DIST_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      qlen_in     = qlen_ff;
      step_in     = step_ff;
      running_in  = running_ff;
      start_in    = start_ff;
      last_in     = last_ff;
      heading_in  = heading_ff;
      drive_in    = drive_ff;
      cur_kind_in = cur_kind_ff;
      cur_dur_in  = cur_dur_ff;
      run_mid     = running_ff;
      move_we     = 1'b0;
      abort       = 1'b0;
      if (req_fire) begin
         case (cmd_type'(req_tuser))
            CMD_TICK: begin
               if (hold) begin
                  drive_in = ACT_STOP;
               end else begin
                  if (running_ff && cur_kind_ff == KIND_DRIVE &&
                      (now_ms - last_ff) > CHECK_INTERVAL_MS) begin
                     last_in = now_ms;
                     if (front_distance_cm < stop_dist_ff) begin
                        drive_in = ACT_STOP;
                        run_mid  = 1'b0;
                        abort    = 1'b1;
                     end
                  end
                  if (run_mid && (now_ms - start_ff) >= {{(TIME_W-DUR_W){1'b0}}, cur_dur_ff}) begin
                     step_in = step_nxt;
                     if (step_nxt >= qlen_ff) begin
                        drive_in = ACT_STOP;
                        run_mid  = 1'b0;
                     end else begin
                        start_in    = now_ms;
                        cur_kind_in = step_kind_ff[nxt_idx];
                        cur_dur_in  = step_dur_ff[nxt_idx];
                        drive_in    = kind_to_action(step_kind_ff[nxt_idx]);
                     end
                  end
                  running_in = run_mid;
               end
            end
            CMD_MOVE: begin
               move_we    = 1'b1;
               qlen_in    = (rel == 2'd0) ? CNT_W'(2) : CNT_W'(5);
               step_in    = '0;
               running_in = 1'b1;
               heading_in = target_heading;
               start_in   = now_ms;
               if (rel == 2'd0) begin
                  cur_kind_in = KIND_DRIVE;
                  cur_dur_in  = cell_ff;
                  drive_in    = ACT_FORWARD;
               end else begin
                  cur_kind_in = KIND_SETTLE;
                  cur_dur_in  = settle_ff;
                  drive_in    = ACT_STOP;
               end
            end
            CMD_CLEAR: begin
               qlen_in    = '0;
               step_in    = '0;
               running_in = 1'b0;
               drive_in   = ACT_STOP;
            end
            default: ;
         endcase
      end
      rsp_data_in = {5'd0, abort, STEP_W'(step_in), heading_in, running_in, drive_in};
   end

   // queue fill on a move
   always_ff @(posedge clock) begin
      if (move_we) begin
         if (rel == 2'd0) begin
            step_kind_ff[0] <= KIND_DRIVE;
            step_dur_ff[0]  <= cell_ff;
            step_kind_ff[1] <= KIND_STOP_ONLY;
            step_dur_ff[1]  <= FINAL_STOP_MS;
         end else begin
            step_kind_ff[0] <= KIND_SETTLE;
            step_dur_ff[0]  <= settle_ff;
            step_kind_ff[1] <= (rel == 2'd3) ? KIND_PIVOT_L : KIND_PIVOT_R;
            step_dur_ff[1]  <= (rel == 2'd2) ? half_ff : quarter_ff;
            step_kind_ff[2] <= KIND_SETTLE;
            step_dur_ff[2]  <= settle_ff;
            step_kind_ff[3] <= KIND_DRIVE;
            step_dur_ff[3]  <= cell_ff;
            step_kind_ff[4] <= KIND_STOP_ONLY;
            step_dur_ff[4]  <= FINAL_STOP_MS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qlen_ff      <= '0;
         step_ff      <= '0;
         running_ff   <= 1'b0;
         start_ff     <= '0;
         last_ff      <= '0;
         heading_ff   <= '0;
         drive_ff     <= ACT_STOP;
         rsp_valid_ff <= 1'b0;
      end else begin
         qlen_ff    <= qlen_in;
         step_ff    <= step_in;
         running_ff <= running_in;
         start_ff   <= start_in;
         last_ff    <= last_in;
         heading_ff <= heading_in;
         drive_ff   <= drive_in;
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_kind_ff <= cur_kind_in;
      cur_dur_ff  <= cur_dur_in;
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `TTDS_ASSERT_NOW(a_step_in_queue, clock, reset, running_ff, step_ff < qlen_ff,
      "running with step outside queue")
   `TTDS_ASSERT_NOW(a_abort_stops, clock, reset, rsp_valid_ff && rsp_data_ff[10],
      !rsp_data_ff[3] && rsp_data_ff[2:0] == ACT_STOP, "abort without stop")
   `TTDS_ASSERT_NEXT(a_move_loads, clock, reset, req_fire && req_tuser == CMD_MOVE,
      running_ff && (qlen_ff == CNT_W'(2) || qlen_ff == CNT_W'(5)), "move did not load queue")
   `TTDS_ASSERT_NEXT(a_clear_idles, clock, reset, req_fire && req_tuser == CMD_CLEAR,
      !running_ff && step_ff == '0 && drive_ff == ACT_STOP, "clear left sequencer active")
   `TTDS_ASSERT_NOW(a_idle_stopped, clock, reset, !running_ff, drive_ff == ACT_STOP,
      "motors driven while idle")

endmodule

@@ bench/timed_turn_and_drive_sequencer_tb.sv @@
`timescale 1ns / 1ps

module timed_turn_and_drive_sequencer_tb;
   import ttds_pkg::*;

   localparam logic [1:0] CMD_NOP    = 2'd3;
   localparam logic [1:0] TURN_RIGHT = 2'd1;
   localparam logic [1:0] TURN_BACK  = 2'd2;
   localparam logic [1:0] TURN_LEFT  = 2'd3;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] now;
      logic [1:0]  target;
      logic [9:0]  front;
      logic        hold;
   } motion_req_type;

   typedef struct packed {
      logic [2:0] act;
      logic       busy;
      logic [1:0] hdg;
      logic [3:0] step;
      logic       abort;
   } motor_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [1:0]            req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CFG_IDX_W-1:0]  csr_index  = '0;
   logic [CFG_DATA_W-1:0] csr_data   = '0;

   timed_turn_and_drive_sequencer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   // predicted sequencer state
   logic [DUR_W-1:0]  cfg_settle  = SETTLE_RST;
   logic [DUR_W-1:0]  cfg_quarter = QUARTER_RST;
   logic [DUR_W-1:0]  cfg_half    = HALF_RST;
   logic [DUR_W-1:0]  cfg_cell    = CELL_RST;
   logic [DIST_W-1:0] cfg_stop_cm = STOP_DIST_RST;

   kind_type          plan_kind [QUEUE_DEPTH_DEF];
   logic [DUR_W-1:0]  plan_dur  [QUEUE_DEPTH_DEF];
   int                plan_len     = 0;
   int                plan_pos     = 0;
   logic [31:0]       step_t0      = '0;
   logic [31:0]       last_range_t = '0;
   logic              plan_active  = 1'b0;
   logic [1:0]        cur_heading  = '0;
   action_type        motor_cmd    = ACT_STOP;

   motor_result_type motor_results_q[$];

   int          fail_count    = 0;
   int          items_sent    = 0;
   int          moves_sent    = 0;
   int          ticks_sent    = 0;
   int          safety_stops  = 0;
   int          writes_done   = 0;
   int          stall_left    = 0;
   int          holdoff_left  = 0;
   bit          tx_burst      = 1'b0;
   bit          rx_burst      = 1'b0;
   logic [31:0] ms_now        = '0;

   function automatic action_type step_motor(input kind_type k);
      case (k)
         KIND_PIVOT_L: return ACT_LEFT;
         KIND_PIVOT_R: return ACT_RIGHT;
         KIND_DRIVE:   return ACT_FORWARD;
         default:      return ACT_STOP;
      endcase
   endfunction

   function automatic void plan_append(input kind_type k, input logic [DUR_W-1:0] d);
      if (plan_len < QUEUE_DEPTH_DEF) begin
         plan_kind[plan_len] = k;
         plan_dur[plan_len]  = d;
         plan_len++;
      end
   endfunction

   function automatic motor_result_type advance_sequencer(input motion_req_type r);
      motor_result_type res;
      logic [1:0]       turn;
      logic [31:0]      since;
      res.abort = 1'b0;
      if (r.cmd == CMD_TICK) begin
         if (r.hold) begin
            motor_cmd = ACT_STOP;
         end else begin
            since = r.now - last_range_t;
            if (plan_active && plan_kind[plan_pos] == KIND_DRIVE && since > CHECK_INTERVAL_MS) begin
               last_range_t = r.now;
               if (r.front < cfg_stop_cm) begin
                  motor_cmd   = ACT_STOP;
                  plan_active = 1'b0;
                  res.abort   = 1'b1;
                  safety_stops++;
               end
            end
            since = r.now - step_t0;
            if (plan_active && since >= {16'd0, plan_dur[plan_pos]}) begin
               plan_pos++;
               if (plan_pos >= plan_len) begin
                  motor_cmd   = ACT_STOP;
                  plan_active = 1'b0;
               end else begin
                  step_t0   = r.now;
                  motor_cmd = step_motor(plan_kind[plan_pos]);
               end
            end
         end
      end else if (r.cmd == CMD_MOVE) begin
         turn        = r.target - cur_heading;
         plan_len    = 0;
         plan_pos    = 0;
         plan_active = 1'b0;
         case (turn)
            TURN_RIGHT: begin
               plan_append(KIND_SETTLE, cfg_settle);
               plan_append(KIND_PIVOT_R, cfg_quarter);
               plan_append(KIND_SETTLE, cfg_settle);
            end
            TURN_LEFT: begin
               plan_append(KIND_SETTLE, cfg_settle);
               plan_append(KIND_PIVOT_L, cfg_quarter);
               plan_append(KIND_SETTLE, cfg_settle);
            end
            TURN_BACK: begin
               plan_append(KIND_SETTLE, cfg_settle);
               plan_append(KIND_PIVOT_R, cfg_half);
               plan_append(KIND_SETTLE, cfg_settle);
            end
            default: ;
         endcase
         plan_append(KIND_DRIVE, cfg_cell);
         plan_append(KIND_STOP_ONLY, FINAL_STOP_MS);
         cur_heading = r.target;
         plan_active = (plan_len > 0);
         step_t0     = r.now;
         if (plan_active) motor_cmd = step_motor(plan_kind[0]);
      end else if (r.cmd == CMD_CLEAR) begin
         plan_len    = 0;
         plan_pos    = 0;
         plan_active = 1'b0;
         motor_cmd   = ACT_STOP;
      end
      res.act  = motor_cmd;
      res.busy = plan_active;
      res.hdg  = cur_heading;
      res.step = plan_pos[3:0];
      return res;
   endfunction

   task automatic compare_field(input string label, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $display("%0t %s mismatch: expected %0d, actual %0d", $time, label, want, got);
         fail_count++;
      end
   endtask

   task automatic check_response(input logic [RSP_DATA_W-1:0] word);
      motor_result_type want;
      if (motor_results_q.size() == 0) begin
         $display("%0t unexpected response: expected none, actual %h", $time, word);
         fail_count++;
      end else begin
         want = motor_results_q.pop_front();
         compare_field("motor_action", want.act, word[2:0]);
         compare_field("busy", want.busy, word[3]);
         compare_field("heading", want.hdg, word[5:4]);
         compare_field("step_index", want.step, word[9:6]);
         compare_field("safety_abort", want.abort, word[10]);
         compare_field("padding", 0, word[15:11]);
      end
   endtask

   // response side: sample at the rising edge, change ready at the falling edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         check_response(rsp_tdata);
         stall_left = rx_burst ? 0 : $urandom_range(0, 11);
      end
   end

   always @(negedge clock) begin
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_request(input logic [1:0] cmd, input logic [31:0] now,
                               input logic [1:0] target, input logic [9:0] front,
                               input logic hold);
      int             gap;
      motion_req_type r;
      gap = tx_burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {3'b000, hold, front, target, now};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r.cmd    = cmd;
      r.now    = now;
      r.target = target;
      r.front  = front;
      r.hold   = hold;
      motor_results_q.push_back(advance_sequencer(r));
      items_sent++;
      if (cmd == CMD_MOVE) moves_sent++;
      if (cmd == CMD_TICK) ticks_sent++;
   endtask

   task automatic wait_all_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (motor_results_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input reg_type idx, input logic [CFG_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_SETTLE:    cfg_settle  = value;
         REG_QUARTER:   cfg_quarter = value;
         REG_HALF:      cfg_half    = value;
         REG_CELL:      cfg_cell    = value;
         REG_STOP_DIST: cfg_stop_cm = value[DIST_W-1:0];
         default: ;
      endcase
      writes_done++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_timing(input logic [15:0] settle, input logic [15:0] quarter,
                             input logic [15:0] half, input logic [15:0] cell_ms,
                             input logic [15:0] stop_cm);
      wait_all_results();
      write_register(REG_SETTLE, settle);
      write_register(REG_QUARTER, quarter);
      write_register(REG_HALF, half);
      write_register(REG_CELL, cell_ms);
      write_register(REG_STOP_DIST, stop_cm);
   endtask

   function automatic logic [15:0] pick_duration();
      if ($urandom_range(0, 3) == 0) return 16'($urandom_range(0, 65535));
      return 16'($urandom_range(0, 300));
   endfunction

   task automatic run_move_sequence(input int inc_max);
      int          n;
      int          pick;
      logic [9:0]  front;
      logic [31:0] inc;
      n = $urandom_range(4, 30);
      ms_now += $urandom_range(0, 40);
      send_request(CMD_MOVE, ms_now, 2'($urandom), 10'($urandom), 1'($urandom));
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            send_request(CMD_CLEAR, $urandom, 2'($urandom), 10'($urandom), 1'($urandom));
         end else if (pick < 5) begin
            send_request(CMD_NOP, $urandom, 2'($urandom), 10'($urandom), 1'($urandom));
         end else if (pick < 7) begin
            send_request(CMD_MOVE, ms_now, 2'($urandom), 10'($urandom), 1'($urandom));
         end else if (pick < 9) begin
            send_request(CMD_TICK, $urandom, 2'($urandom), 10'($urandom), 1'b0);
         end else begin
            inc = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, inc_max);
            ms_now += inc;
            front = 10'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                    : $urandom_range(cfg_stop_cm, 1023));
            send_request(CMD_TICK, ms_now, 2'($urandom), front, pick < 17);
         end
      end
   endtask

   task automatic test_directed_moves();
      send_request(CMD_TICK, 32'd0, 2'd0, 10'd0, 1'b0);
      send_request(CMD_NOP, 32'hFFFF_FFFF, 2'd3, 10'd1023, 1'b1);
      send_request(CMD_CLEAR, 32'd5, 2'd0, 10'd0, 1'b0);
      // right turn, hold, then obstacle right at the distance limit
      send_request(CMD_MOVE, 32'd1000, 2'd1, 10'd500, 1'b0);
      send_request(CMD_TICK, 32'd1099, 2'd0, 10'd500, 1'b0);
      send_request(CMD_TICK, 32'd1100, 2'd0, 10'd500, 1'b0);
      send_request(CMD_TICK, 32'd1200, 2'd0, 10'd500, 1'b1);
      send_request(CMD_TICK, 32'd1400, 2'd0, 10'd500, 1'b0);
      send_request(CMD_TICK, 32'd1500, 2'd0, 10'd500, 1'b0);
      send_request(CMD_TICK, 32'd1540, 2'd0, 10'd8, 1'b0);
      send_request(CMD_TICK, 32'd1590, 2'd0, 10'd7, 1'b0);
      send_request(CMD_TICK, 32'd1591, 2'd0, 10'd7, 1'b0);
      // reversal, cleared mid pivot
      send_request(CMD_MOVE, 32'd2000, 2'd3, 10'd0, 1'b0);
      send_request(CMD_TICK, 32'd2100, 2'd0, 10'd1023, 1'b0);
      send_request(CMD_CLEAR, 32'd2150, 2'd0, 10'd0, 1'b0);
      // left turn run to completion
      send_request(CMD_MOVE, 32'd3000, 2'd2, 10'd0, 1'b0);
      send_request(CMD_TICK, 32'd3100, 2'd0, 10'd1023, 1'b0);
      send_request(CMD_TICK, 32'd3400, 2'd0, 10'd1023, 1'b0);
      send_request(CMD_TICK, 32'd3500, 2'd0, 10'd1023, 1'b0);
      send_request(CMD_TICK, 32'd4000, 2'd0, 10'd1023, 1'b0);
      send_request(CMD_TICK, 32'd4010, 2'd0, 10'd1023, 1'b0);
      // straight ahead across the time wrap
      send_request(CMD_MOVE, 32'hFFFF_FFF0, 2'd2, 10'd0, 1'b0);
      send_request(CMD_TICK, 32'h0000_0204, 2'd0, 10'd1023, 1'b0);
      send_request(CMD_TICK, 32'h0000_020E, 2'd0, 10'd1023, 1'b0);
   endtask

   task automatic test_register_extremes();
      logic [31:0] t;
      set_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      t = 32'h8000_0000;
      send_request(CMD_MOVE, t, 2'd3, 10'd0, 1'b0);
      repeat (6) send_request(CMD_TICK, t, 2'd0, 10'd0, 1'b0);
      send_request(CMD_TICK, t + 32'd10, 2'd0, 10'd0, 1'b0);
      set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1023);
      send_request(CMD_MOVE, t, 2'd1, 10'd0, 1'b0);
      send_request(CMD_TICK, t + 32'd65534, 2'd0, 10'd1023, 1'b0);
      repeat (4) begin
         t += 32'd65535;
         send_request(CMD_TICK, t, 2'd0, 10'd1023, 1'b0);
      end
      send_request(CMD_TICK, t + 32'd60, 2'd0, 10'd1023, 1'b0);
      send_request(CMD_TICK, t + 32'd120, 2'd0, 10'd1022, 1'b0);
   endtask

   task automatic test_random_traffic();
      int stop_item;
      int inc_max;
      for (int ph = 0; ph < 6; ph++) begin
         set_timing(pick_duration(), pick_duration(), pick_duration(), pick_duration(),
                    16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                    : $urandom_range(0, 40)));
         tx_burst  = (ph % 3 == 1);
         rx_burst  = (ph % 3 == 1);
         ms_now    = (ph == 4) ? 32'hFFFF_F000 : $urandom;
         inc_max   = $urandom_range(5, 150);
         stop_item = items_sent + 170;
         while (items_sent < stop_item) run_move_sequence(inc_max);
      end
      tx_burst = 1'b0;
      rx_burst = 1'b0;
   endtask

   task automatic test_output_backpressure();
      set_timing(16'd20, 16'd40, 16'd80, 16'd100, 16'd10);
      tx_burst = 1'b1;
      holdoff_left = 60;
      ms_now += 32'd100;
      send_request(CMD_MOVE, ms_now, 2'($urandom), 10'd0, 1'b0);
      repeat (23) begin
         ms_now += $urandom_range(0, 30);
         send_request(CMD_TICK, ms_now, 2'd0, 10'($urandom_range(10, 1023)), 1'b0);
      end
      tx_burst = 1'b0;
      // sender holds until the block is empty
      wait_all_results();
      run_move_sequence(30);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_moves();
      test_register_extremes();
      test_random_traffic();
      test_output_backpressure();
      wait_all_results();
      repeat (8) @(posedge clock);
      $display("covered %0d requests: %0d moves, %0d ticks, %0d obstacle stops",
               items_sent, moves_sent, ticks_sent, safety_stops);
      $display("%0d register writes over reset, zero, full-scale and random timings",
               writes_done);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hdl
hdl/ttds_pkg.sv
hdl/timed_turn_and_drive_sequencer.sv
bench/timed_turn_and_drive_sequencer_tb.sv
